// File: rtl/qpe_pkg.sv
// Shared types, character codes and helpers for the quoted-printable encoder.
// No dependencies; every other file but qpe_checker imports this package.
`default_nettype none
package qpe_pkg;

  localparam int LINE_W = 7;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_EQ  = 8'd61;
  localparam logic [7:0] LIT_LO_A = 8'd33;
  localparam logic [7:0] LIT_HI_A = 8'd60;
  localparam logic [7:0] LIT_LO_B = 8'd62;
  localparam logic [7:0] LIT_HI_B = 8'd126;

  localparam logic [LINE_W-1:0] WS_LIMIT  = 7'd74;
  localparam logic [LINE_W-1:0] LIT_LIMIT = 7'd75;
  localparam logic [LINE_W-1:0] ESC_LIMIT = 7'd73;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_LF  = 2'd1,
    KIND_ESC = 2'd2
  } qpe_kind_t;

  // One queued run of output characters.
  typedef struct packed {
    logic       brk;
    qpe_kind_t  kind;
    logic [7:0] data;
  } qpe_desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'd48 + {4'd0, nib};
    end else begin
      r = 8'd55 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/qpe_front.sv
// Front end: accepts message bytes, tracks the line count and classifies
// each byte into a run descriptor. Depends on qpe_pkg.
`default_nettype none
module qpe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_start_of_message,
  output qpe_pkg::qpe_desc_t     push_desc,
  output logic                   push
);
  import qpe_pkg::*;

  logic [LINE_W-1:0] line_count_r, line_count_nxt, cnt0, base;
  logic is_ws, is_lit, is_cr, is_lf, is_esc, brk, accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    is_ws  = (in_byte == CH_SP) || (in_byte == CH_TAB);
    is_lit = ((in_byte >= LIT_LO_A) && (in_byte <= LIT_HI_A)) ||
             ((in_byte >= LIT_LO_B) && (in_byte <= LIT_HI_B));
    is_cr  = (in_byte == CH_CR);
    is_lf  = (in_byte == CH_LF);
    is_esc = !is_ws && !is_lit && !is_cr && !is_lf;
    cnt0   = in_start_of_message ? '0 : line_count_r;
    brk    = (is_ws && (cnt0 >= WS_LIMIT)) || (is_lit && (cnt0 >= LIT_LIMIT)) ||
             (is_esc && (cnt0 >= ESC_LIMIT));
    base   = brk ? '0 : cnt0;

    if (is_ws || is_lit) begin
      line_count_nxt = base + 7'd1;
    end else if (is_esc) begin
      line_count_nxt = base + 7'd3;
    end else if (is_lf) begin
      line_count_nxt = '0;
    end else begin
      line_count_nxt = cnt0;
    end

    push_desc.brk  = brk;
    push_desc.data = in_byte;
    if (is_lf) begin
      push_desc.kind = KIND_LF;
    end else if (is_esc) begin
      push_desc.kind = KIND_ESC;
    end else begin
      push_desc.kind = KIND_LIT;
    end
    // A dropped CR produces nothing downstream.
    push = accept && !is_cr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
    end else if (accept) begin
      line_count_r <= line_count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/qpe_fifo.sv
// Short descriptor queue between the front and back ends.
// Depends on qpe_pkg for the descriptor type.
`default_nettype none
module qpe_fifo #(
  parameter int DEPTH = qpe_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire qpe_pkg::qpe_desc_t wr_data,
  input  wire logic               rd_en,
  output qpe_pkg::qpe_desc_t      rd_data,
  output logic                    not_empty,
  output logic                    full
);
  import qpe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qpe_desc_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_data   = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= inc_ptr(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= inc_ptr(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/qpe_back.sv
// Back end: expands each queued descriptor into its output characters,
// one word per cycle while out_stall is low, through an output register. Depends on qpe_pkg.
`default_nettype none
module qpe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qpe_pkg::qpe_desc_t head,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last_of_run
);
  import qpe_pkg::*;

  logic [2:0] idx_r, idx_nxt, off, total, j;
  logic       out_valid_r, out_valid_nxt, out_last_r, last, load, slot_free;
  logic [7:0] out_byte_r, ch;

  always_comb begin
    off = head.brk ? 3'd3 : 3'd0;
    case (head.kind)
      KIND_LIT: total = off + 3'd1;
      KIND_LF:  total = off + 3'd2;
      KIND_ESC: total = off + 3'd3;
      default:  total = off + 3'd1;
    endcase
    j    = idx_r - off;
    last = (idx_r == total - 3'd1);

    if (head.brk && (idx_r < 3'd3)) begin
      case (idx_r)
        3'd0:    ch = CH_EQ;
        3'd1:    ch = CH_CR;
        default: ch = CH_LF;
      endcase
    end else begin
      case (head.kind)
        KIND_LIT: ch = head.data;
        KIND_LF:  ch = (j == 3'd0) ? CH_CR : CH_LF;
        KIND_ESC: begin
          case (j)
            3'd0:    ch = CH_EQ;
            3'd1:    ch = hex_char(head.data[7:4]);
            default: ch = hex_char(head.data[3:0]);
          endcase
        end
        default:  ch = head.data;
      endcase
    end

    slot_free     = !out_valid_r || !out_stall;
    load          = head_valid && slot_free;
    pop           = load && last;
    out_valid_nxt = slot_free ? head_valid : out_valid_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (load) begin
      idx_nxt = idx_r + 3'd1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ch;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

// File: rtl/quoted_printable_encoder.sv
// Quoted-printable encoder top level: front end, descriptor queue, back end.
// Depends on qpe_pkg, qpe_front, qpe_fifo and qpe_back.
//
// Usage:
// - Input channel (in_valid / in_stall): one message byte per word, with
//   in_start_of_message set on the first byte of a message to restart the
//   line count. CR bytes are consumed and produce nothing.
// - Output channel (out_valid / out_stall): one encoded character per word;
//   out_last_of_run marks the final character caused by an input byte.
// - Path: an accepted byte is written into the descriptor queue, and its first
//   character is then loaded from the queue head into the output register.
// - Throughput: while out_stall is low the output side moves one character per
//   cycle. An input byte producing k characters (1 to 6) occupies the back end
//   until all k are sent, so plain text runs at one byte per cycle; escapes and
//   soft breaks slow the input only once the FIFO_DEPTH-entry queue has filled.
// - Reset (rst_n low, synchronous) clears the line count, the queue and the
//   valid flag of the output register.
// - While out_stall is high the held word stays unchanged; the queue keeps
//   taking input until it is full, then in_stall rises.
`default_nettype none
module quoted_printable_encoder #(
  parameter int FIFO_DEPTH = qpe_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_start_of_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);
  import qpe_pkg::*;

  qpe_desc_t push_desc, head;
  logic      push, pop, head_valid, full;

  assign in_stall = full;

  qpe_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .in_start_of_message (in_start_of_message),
    .push_desc           (push_desc),
    .push                (push)
  );

  qpe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_data   (push_desc),
    .rd_en     (pop),
    .rd_data   (head),
    .not_empty (head_valid),
    .full      (full)
  );

  qpe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// File: rtl/qpe_checker.sv
// Port-level assertions for the quoted-printable encoder, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module qpe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A CR never ends a run (it is always followed by an LF of the same run).
  a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == 8'd13) |-> !out_last_of_run)
    else $error("CR ended a run");

  // Only printable ASCII, tab, CR and LF ever leave the encoder.
  a_out_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte == 8'd9) || (out_byte == 8'd10) || (out_byte == 8'd13) ||
                  ((out_byte >= 8'd32) && (out_byte <= 8'd126)))
    else $error("non-printable output character");

  // With nothing held or queued downstream after reset, input is taken.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire
